// ===== rtl/koq_pkg.sv =====
// Request and status codes shared by the keyed ordered queue.
`default_nettype none

package koq_pkg;

  typedef enum logic [2:0] {
    REQ_INSERT = 3'd0,
    REQ_REMOVE = 3'd1,
    REQ_POP    = 3'd2,
    REQ_LOOKUP = 3'd3,
    REQ_PEEK   = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_DUP     = 3'd1,
    ST_MISSING = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

endpackage

`default_nettype wire

// ===== rtl/keyed_ordered_queue.sv =====
// Top level of the keyed ordered queue: slot table, request stage and result register.
`default_nettype none

// The queue holds up to CAPACITY unique keys with payloads in insertion order,
// in a compacted table of flip-flops where slot 0 is the head. Each request beat
// (insert, remove by key, pop, lookup, peek) is captured in an input register and
// resolved as it moves into the result register, by a parallel compare of its
// key against every occupied slot; removals shift the later slots one place
// toward the head in the same cycle. One request is accepted every cycle unless
// the result side stalls, which holds both the input and the result register.
// Request codes five to seven are ignored and answer ok with zero key and payload.
module keyed_ordered_queue #(
  parameter int CAPACITY  = 16,
  parameter int KEY_BITS  = 16,
  parameter int DATA_BITS = 32
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire  [2:0]                       req_type_i,
  input  wire  [KEY_BITS-1:0]              key_i,
  input  wire  [DATA_BITS-1:0]             payload_i,
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output koq_pkg::status_e                 status_o,
  output logic [KEY_BITS-1:0]              found_key_o,
  output logic [DATA_BITS-1:0]             found_payload_o,
  output logic [$clog2(CAPACITY+1)-1:0]    entry_count_o
);
  import koq_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                 req_valid_q;
  logic [2:0]           req_type_q;
  logic [KEY_BITS-1:0]  req_key_q;
  logic [DATA_BITS-1:0] req_data_q;

  logic [KEY_BITS-1:0]  slot_key_q  [CAPACITY];
  logic [DATA_BITS-1:0] slot_data_q [CAPACITY];
  logic [CNT_W-1:0]     occ_q, occ_d;

  logic                 res_valid_q;
  status_e              res_status_q, res_status_d;
  logic [KEY_BITS-1:0]  res_key_q, res_key_d;
  logic [DATA_BITS-1:0] res_data_q, res_data_d;

  logic                 fire;
  logic [CAPACITY-1:0]  match;
  logic                 hit;
  logic [IDX_W-1:0]     hit_idx, drop_idx;
  logic [KEY_BITS-1:0]  hit_key;
  logic [DATA_BITS-1:0] hit_data;
  logic                 do_insert, do_drop, empty, full;

  assign fire       = req_valid_q && !(res_valid_q && out_stall_i);
  assign in_stall_o = req_valid_q && !fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      req_type_q <= req_type_i;
      req_key_q  <= key_i;
      req_data_q <= payload_i;
    end
  end

  always_comb begin
    hit_idx  = '0;
    hit_key  = '0;
    hit_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = (CNT_W'(i) < occ_q) && (slot_key_q[i] == req_key_q);
      if (match[i]) begin
        hit_idx  = hit_idx | IDX_W'(i);
        hit_key  = hit_key | slot_key_q[i];
        hit_data = hit_data | slot_data_q[i];
      end
    end
  end

  assign hit   = |match;
  assign empty = (occ_q == '0);
  assign full  = (occ_q == CNT_W'(CAPACITY));

  always_comb begin
    res_status_d = ST_OK;
    res_key_d    = '0;
    res_data_d   = '0;
    do_insert    = 1'b0;
    do_drop      = 1'b0;
    drop_idx     = '0;
    case (req_type_q)
      REQ_INSERT: begin
        if (hit) begin
          res_status_d = ST_DUP;
        end else if (full) begin
          res_status_d = ST_FULL;
        end else begin
          do_insert  = 1'b1;
          res_key_d  = req_key_q;
          res_data_d = req_data_q;
        end
      end
      REQ_REMOVE, REQ_LOOKUP: begin
        if (!hit) begin
          res_status_d = ST_MISSING;
        end else begin
          res_key_d  = hit_key;
          res_data_d = hit_data;
          do_drop    = (req_type_q == REQ_REMOVE);
          drop_idx   = hit_idx;
        end
      end
      REQ_POP, REQ_PEEK: begin
        if (empty) begin
          res_status_d = ST_EMPTY;
        end else begin
          res_key_d  = slot_key_q[0];
          res_data_d = slot_data_q[0];
          do_drop    = (req_type_q == REQ_POP);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    occ_d = occ_q;
    if (do_insert) begin
      occ_d = occ_q + CNT_W'(1);
    end else if (do_drop) begin
      occ_d = occ_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (do_drop && (IDX_W'(i) >= drop_idx) && (i < CAPACITY - 1)) begin
          slot_key_q[i]  <= slot_key_q[(i + 1) % CAPACITY];
          slot_data_q[i] <= slot_data_q[(i + 1) % CAPACITY];
        end else if (do_insert && (CNT_W'(i) == occ_q)) begin
          slot_key_q[i]  <= req_key_q;
          slot_data_q[i] <= req_data_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        occ_q <= occ_d;
      end
      if (fire) begin
        res_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_status_q  <= res_status_d;
      res_key_q     <= res_key_d;
      res_data_q    <= res_data_d;
      entry_count_o <= occ_d;
    end
  end

  assign out_valid_o     = res_valid_q;
  assign status_o        = res_status_q;
  assign found_key_o     = res_key_q;
  assign found_payload_o = res_data_q;

endmodule

`default_nettype wire
